@@ rtl/assert_macros.svh @@
// Concurrent assertion shorthands; the including module supplies clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/segi_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the segment intersection unit
package segi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TOL_BITS = 34;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_POINT     = 2'd1,
		ST_COLLINEAR = 2'd2
	} status_t;

endpackage

@@ rtl/segi_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two numerator lanes over one divisor, one quotient bit per stage
module segi_div #(
	parameter int NQW = 3 * segi_pkg::COORD_BITS_DEF + 3,
	parameter int DVW = 2 * segi_pkg::COORD_BITS_DEF + 2,
	parameter int SW  = 8 * segi_pkg::COORD_BITS_DEF + 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [NQW-1:0] in_num_x,
	input  logic [NQW-1:0] in_num_y,
	input  logic [DVW-1:0] in_den,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [NQW-1:0] out_quo_x,
	output logic [NQW-1:0] out_quo_y,
	output logic [SW-1:0]  out_side
);

	logic           v_s    [NQW];
	logic [NQW-1:0] nqx_s  [NQW];
	logic [NQW-1:0] nqy_s  [NQW];
	logic [DVW-1:0] remx_s [NQW];
	logic [DVW-1:0] remy_s [NQW];
	logic [DVW-1:0] den_s  [NQW];
	logic [SW-1:0]  side_s [NQW];

	for (genvar k = 0; k < NQW; k++) begin : g_stage
		logic           v_i;
		logic [NQW-1:0] nqx_i, nqy_i;
		logic [DVW-1:0] remx_i, remy_i, den_i;
		logic [SW-1:0]  side_i;
		logic [DVW:0]   tx, ty, subx, suby;
		logic           gex, gey;

		if (k == 0) begin : g_head
			assign v_i    = in_valid;
			assign nqx_i  = in_num_x;
			assign nqy_i  = in_num_y;
			assign remx_i = '0;
			assign remy_i = '0;
			assign den_i  = in_den;
			assign side_i = in_side;
		end else begin : g_tail
			assign v_i    = v_s[k-1];
			assign nqx_i  = nqx_s[k-1];
			assign nqy_i  = nqy_s[k-1];
			assign remx_i = remx_s[k-1];
			assign remy_i = remy_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign tx   = {remx_i, nqx_i[NQW-1]};
		assign ty   = {remy_i, nqy_i[NQW-1]};
		assign subx = tx - {1'b0, den_i};
		assign suby = ty - {1'b0, den_i};
		assign gex  = (tx >= {1'b0, den_i});
		assign gey  = (ty >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nqx_s[k]  <= {nqx_i[NQW-2:0], gex};
				nqy_s[k]  <= {nqy_i[NQW-2:0], gey};
				remx_s[k] <= gex ? subx[DVW-1:0] : tx[DVW-1:0];
				remy_s[k] <= gey ? suby[DVW-1:0] : ty[DVW-1:0];
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NQW-1];
	assign out_quo_x = nqx_s[NQW-1];
	assign out_quo_y = nqy_s[NQW-1];
	assign out_side  = side_s[NQW-1];

endmodule

@@ rtl/segment_intersection_unit.sv @@
`timescale 1ns / 1ps
// Segment intersection unit: crossing point of two 2D segments, fully pipelined
//
//  channel  handshake                  payload
//  item     item_valid / item_stall    a_x a_y b_x b_y c_x c_y d_x d_y
//  res      res_valid / res_stall      status cross_x cross_y
//  cfg      cfg_valid / cfg_ready      cfg_data (tolerance)
//
// One item enters per cycle while item_stall is low; the divider yields one quotient bit
// per stage.
// Reset clears the stage valid bits, the output and skid valid flags and the tolerance.
// A stalled result waits in the output register; the next one parks in a skid register,
// and only a full skid register stalls the item side.
`include "assert_macros.svh"

module segment_intersection_unit #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [segi_pkg::TOL_BITS-1:0] cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	input  logic signed [COORD_BITS-1:0]  d_x,
	input  logic signed [COORD_BITS-1:0]  d_y,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    status,
	output logic signed [COORD_BITS-1:0]  cross_x,
	output logic signed [COORD_BITS-1:0]  cross_y
);

	import segi_pkg::*;

	localparam int W   = COORD_BITS;
	localparam int TW  = TOL_BITS;
	localparam int DFW = W + 1;
	localparam int PW  = 2 * W + 2;
	localparam int DW  = 2 * W + 3;
	localparam int PPW = 2 * W + 3;
	localparam int NW  = 3 * W + 4;
	localparam int NQW = 3 * W + 3;
	localparam int DVW = 2 * W + 2;
	localparam int CW  = ((DW > TW) ? DW : TW) + 1;
	localparam int XW  = ((NW + 1) > (TW + 1)) ? (NW + 1) : (TW + 1);
	localparam int TPW = 2 * TW;

	localparam logic signed [NW-1:0] CMAX = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [NW-1:0] CMIN = {{(NW-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef struct packed {
		logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} pts_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic dz;
		logic col_ok;
		pts_t pts;
	} side_t;

	localparam int SW = $bits(side_t);

	logic          adv;
	logic [TW-1:0] tol_q;

	// stage 1
	logic                  v_s1;
	pts_t                  pts_s1;
	logic signed [DFW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	// stage 2
	logic                  v_s2;
	pts_t                  pts_s2;
	logic signed [DFW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [PW-1:0]  md1_s2, md2_s2, mp1_s2, mp2_s2, mq1_s2, mq2_s2, mc1_s2, mc2_s2;
	// stage 3
	logic                  v_s3;
	pts_t                  pts_s3;
	logic signed [DFW-1:0] ux_s3, uy_s3, vx_s3, vy_s3;
	logic signed [DW-1:0]  delta_s3, p_s3, q_s3, col_s3;
	// stage 4
	logic                  v_s4;
	pts_t                  pts_s4;
	logic signed [DW-1:0]  delta_s4;
	logic                  dz_s4, col_ok_s4;
	logic signed [PPW-1:0] uxql_s4, uxqh_s4, vxpl_s4, vxph_s4;
	logic signed [PPW-1:0] uyql_s4, uyqh_s4, vypl_s4, vyph_s4;
	logic [DW-1:0]         col_abs;
	// stage 5
	logic                  v_s5;
	pts_t                  pts_s5;
	logic signed [DW-1:0]  delta_s5;
	logic                  dz_s5, col_ok_s5;
	logic signed [NW-1:0]  nx_s5, ny_s5;
	// stage 6
	logic                  v_s6;
	side_t                 side_s6;
	logic [NQW-1:0]        numx_s6, numy_s6;
	logic [DVW-1:0]        den_s6;
	logic signed [NW-1:0]  nx_neg, ny_neg;
	logic signed [DW-1:0]  delta_neg;
	// divider
	logic                  dv_valid;
	logic [NQW-1:0]        dv_quo_x, dv_quo_y;
	logic [SW-1:0]         dv_side_raw;
	side_t                 dv_side;
	logic signed [NW-1:0]  qx_pos, qy_pos;
	// stage 7
	logic                  v_s7;
	pts_t                  pts_s7;
	logic                  dz_s7, col_ok_s7;
	logic signed [NW-1:0]  qx_s7, qy_s7;
	// stage 8
	logic                  v_s8;
	logic                  dz_s8, col_ok_s8;
	logic signed [XW-1:0]  ea_s8 [4];
	logic signed [XW-1:0]  eb_s8 [4];
	logic [W-1:0]          satx_s8, saty_s8;
	// stage 9
	logic                  v_s9;
	logic                  dz_s9, col_ok_s9;
	logic [W-1:0]          satx_s9, saty_s9;
	logic [3:0]            triv_s9, big_s9;
	logic [TW-1:0]         ma_s9 [4];
	logic [TW-1:0]         mb_s9 [4];
	logic [XW-1:0]         aa [4];
	logic [XW-1:0]         ab [4];
	// stage 10
	logic                  v_s10;
	logic                  dz_s10, col_ok_s10;
	logic [W-1:0]          satx_s10, saty_s10;
	logic [3:0]            triv_s10, big_s10;
	logic [TPW-1:0]        pr_s10 [4];
	// stage 11
	logic                  v_s11;
	status_t               st_s11;
	logic [W-1:0]          x_s11, y_s11;
	logic [3:0]            span_ok;
	logic                  hit;
	// output and skid
	logic                  res_valid_q, skid_v_q;
	status_t               res_status_q, skid_status_q;
	logic [W-1:0]          res_x_q, res_y_q, skid_x_q, skid_y_q;

	assign adv        = !skid_v_q;
	assign item_stall = skid_v_q;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= dv_valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_comb begin
		col_abs   = col_s3[DW-1] ? DW'(-col_s3) : DW'(col_s3);
		nx_neg    = -nx_s5;
		ny_neg    = -ny_s5;
		delta_neg = -delta_s5;
		dv_side   = side_t'(dv_side_raw);
		qx_pos    = $signed({1'b0, dv_quo_x});
		qy_pos    = $signed({1'b0, dv_quo_y});
		for (int j = 0; j < 4; j++) begin
			aa[j] = ea_s8[j][XW-1] ? XW'(-ea_s8[j]) : XW'(ea_s8[j]);
			ab[j] = eb_s8[j][XW-1] ? XW'(-eb_s8[j]) : XW'(eb_s8[j]);
		end
		for (int j = 0; j < 4; j++) begin
			span_ok[j] = triv_s10[j] || (!big_s10[j] && (pr_s10[j] <= TPW'(tol_q)));
		end
		hit = !dz_s10 && (&span_ok);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// differences
			pts_s1 <= '{ax: a_x, ay: a_y, bx: b_x, by: b_y,
				cx: c_x, cy: c_y, dx: d_x, dy: d_y};
			ux_s1 <= DFW'(b_x) - DFW'(a_x);
			uy_s1 <= DFW'(b_y) - DFW'(a_y);
			vx_s1 <= DFW'(d_x) - DFW'(c_x);
			vy_s1 <= DFW'(d_y) - DFW'(c_y);
			wx_s1 <= DFW'(c_x) - DFW'(a_x);
			wy_s1 <= DFW'(c_y) - DFW'(a_y);

			// first products
			pts_s2 <= pts_s1;
			ux_s2  <= ux_s1;
			uy_s2  <= uy_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			md1_s2 <= PW'(ux_s1) * PW'(vy_s1);
			md2_s2 <= PW'(uy_s1) * PW'(vx_s1);
			mp1_s2 <= PW'(ux_s1) * PW'($signed(pts_s1.ay));
			mp2_s2 <= PW'(uy_s1) * PW'($signed(pts_s1.ax));
			mq1_s2 <= PW'($signed(pts_s1.cx)) * PW'(vy_s1);
			mq2_s2 <= PW'($signed(pts_s1.cy)) * PW'(vx_s1);
			mc1_s2 <= PW'(ux_s1) * PW'(wy_s1);
			mc2_s2 <= PW'(uy_s1) * PW'(wx_s1);

			// determinants
			pts_s3   <= pts_s2;
			ux_s3    <= ux_s2;
			uy_s3    <= uy_s2;
			vx_s3    <= vx_s2;
			vy_s3    <= vy_s2;
			delta_s3 <= DW'(md1_s2) - DW'(md2_s2);
			p_s3     <= DW'(mp1_s2) - DW'(mp2_s2);
			q_s3     <= DW'(mq1_s2) - DW'(mq2_s2);
			col_s3   <= DW'(mc1_s2) - DW'(mc2_s2);

			// split partial products of the numerators
			pts_s4    <= pts_s3;
			delta_s4  <= delta_s3;
			dz_s4     <= (delta_s3 == '0);
			col_ok_s4 <= (CW'(col_abs) <= CW'(tol_q));
			uxql_s4   <= PPW'(ux_s3) * PPW'($signed({1'b0, q_s3[W:0]}));
			uxqh_s4   <= PPW'(ux_s3) * PPW'($signed(q_s3[DW-1:W+1]));
			vxpl_s4   <= PPW'(vx_s3) * PPW'($signed({1'b0, p_s3[W:0]}));
			vxph_s4   <= PPW'(vx_s3) * PPW'($signed(p_s3[DW-1:W+1]));
			uyql_s4   <= PPW'(uy_s3) * PPW'($signed({1'b0, q_s3[W:0]}));
			uyqh_s4   <= PPW'(uy_s3) * PPW'($signed(q_s3[DW-1:W+1]));
			vypl_s4   <= PPW'(vy_s3) * PPW'($signed({1'b0, p_s3[W:0]}));
			vyph_s4   <= PPW'(vy_s3) * PPW'($signed(p_s3[DW-1:W+1]));

			// numerators
			pts_s5    <= pts_s4;
			delta_s5  <= delta_s4;
			dz_s5     <= dz_s4;
			col_ok_s5 <= col_ok_s4;
			nx_s5     <= (NW'(uxqh_s4) <<< (W + 1)) + NW'(uxql_s4)
				+ (NW'(vxph_s4) <<< (W + 1)) + NW'(vxpl_s4);
			ny_s5     <= (NW'(uyqh_s4) <<< (W + 1)) + NW'(uyql_s4)
				+ (NW'(vyph_s4) <<< (W + 1)) + NW'(vypl_s4);

			// magnitudes and quotient signs
			side_s6.sx     <= nx_s5[NW-1] ^ delta_s5[DW-1];
			side_s6.sy     <= ny_s5[NW-1] ^ delta_s5[DW-1];
			side_s6.dz     <= dz_s5;
			side_s6.col_ok <= col_ok_s5;
			side_s6.pts    <= pts_s5;
			numx_s6        <= nx_s5[NW-1] ? nx_neg[NQW-1:0] : nx_s5[NQW-1:0];
			numy_s6        <= ny_s5[NW-1] ? ny_neg[NQW-1:0] : ny_s5[NQW-1:0];
			den_s6         <= delta_s5[DW-1] ? delta_neg[DVW-1:0] : delta_s5[DVW-1:0];

			// signed quotients
			pts_s7    <= dv_side.pts;
			dz_s7     <= dv_side.dz;
			col_ok_s7 <= dv_side.col_ok;
			qx_s7     <= dv_side.sx ? -qx_pos : qx_pos;
			qy_s7     <= dv_side.sy ? -qy_pos : qy_pos;

			// span offsets and saturation
			dz_s8     <= dz_s7;
			col_ok_s8 <= col_ok_s7;
			ea_s8[0]  <= XW'(qx_s7) - XW'($signed(pts_s7.cx));
			eb_s8[0]  <= XW'(qx_s7) - XW'($signed(pts_s7.dx));
			ea_s8[1]  <= XW'(qy_s7) - XW'($signed(pts_s7.cy));
			eb_s8[1]  <= XW'(qy_s7) - XW'($signed(pts_s7.dy));
			ea_s8[2]  <= XW'(qx_s7) - XW'($signed(pts_s7.ax));
			eb_s8[2]  <= XW'(qx_s7) - XW'($signed(pts_s7.bx));
			ea_s8[3]  <= XW'(qy_s7) - XW'($signed(pts_s7.ay));
			eb_s8[3]  <= XW'(qy_s7) - XW'($signed(pts_s7.by));
			satx_s8   <= (qx_s7 > CMAX) ? CMAX[W-1:0] :
				(qx_s7 < CMIN) ? CMIN[W-1:0] : qx_s7[W-1:0];
			saty_s8   <= (qy_s7 > CMAX) ? CMAX[W-1:0] :
				(qy_s7 < CMIN) ? CMIN[W-1:0] : qy_s7[W-1:0];

			// span magnitudes
			dz_s9     <= dz_s8;
			col_ok_s9 <= col_ok_s8;
			satx_s9   <= satx_s8;
			saty_s9   <= saty_s8;
			for (int j = 0; j < 4; j++) begin
				triv_s9[j] <= (ea_s8[j] == '0) || (eb_s8[j] == '0)
					|| (ea_s8[j][XW-1] != eb_s8[j][XW-1]);
				big_s9[j]  <= (|aa[j][XW-1:TW]) || (|ab[j][XW-1:TW]);
				ma_s9[j]   <= aa[j][TW-1:0];
				mb_s9[j]   <= ab[j][TW-1:0];
			end

			// span products
			dz_s10     <= dz_s9;
			col_ok_s10 <= col_ok_s9;
			satx_s10   <= satx_s9;
			saty_s10   <= saty_s9;
			triv_s10   <= triv_s9;
			big_s10    <= big_s9;
			for (int j = 0; j < 4; j++) begin
				pr_s10[j] <= TPW'(ma_s9[j]) * TPW'(mb_s9[j]);
			end

			// classify
			if (dz_s10) begin
				st_s11 <= col_ok_s10 ? ST_COLLINEAR : ST_NONE;
			end else begin
				st_s11 <= hit ? ST_POINT : ST_NONE;
			end
			x_s11 <= hit ? satx_s10 : '0;
			y_s11 <= hit ? saty_s10 : '0;
		end
	end

	segi_div #(
		.NQW (NQW),
		.DVW (DVW),
		.SW  (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s6),
		.in_num_x  (numx_s6),
		.in_num_y  (numy_s6),
		.in_den    (den_s6),
		.in_side   (SW'(side_s6)),
		.out_valid (dv_valid),
		.out_quo_x (dv_quo_x),
		.out_quo_y (dv_quo_y),
		.out_side  (dv_side_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= skid_v_q || v_s11;
			skid_v_q    <= 1'b0;
		end else if (adv && v_s11) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			if (skid_v_q) begin
				res_status_q <= skid_status_q;
				res_x_q      <= skid_x_q;
				res_y_q      <= skid_y_q;
			end else begin
				res_status_q <= st_s11;
				res_x_q      <= x_s11;
				res_y_q      <= y_s11;
			end
		end else if (adv) begin
			skid_status_q <= st_s11;
			skid_x_q      <= x_s11;
			skid_y_q      <= y_s11;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = res_status_q;
	assign cross_x   = res_x_q;
	assign cross_y   = res_y_q;

	`ASSERT_SAME(a_skid_needs_out, skid_v_q, res_valid_q)
	`ASSERT_NEXT(a_skid_drains, skid_v_q && !res_stall, res_valid_q && !skid_v_q)
	`ASSERT_SAME(a_no_point_zero, res_valid_q && res_status_q != ST_POINT, res_x_q == '0 && res_y_q == '0)

endmodule
